/* design/cle_pkg.sv */
// ----------------------------------------------------------------------------
// Circular list engine package
// Operation codes, status codes and channel widths shared by the design.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam logic [2:0] OP_ADD_FRONT = 3'd0;
   localparam logic [2:0] OP_ADD_BACK  = 3'd1;
   localparam logic [2:0] OP_INS_KEY   = 3'd2;
   localparam logic [2:0] OP_DEL_FRONT = 3'd3;
   localparam logic [2:0] OP_DEL_BACK  = 3'd4;
   localparam logic [2:0] OP_DEL_KEY   = 3'd5;
   localparam logic [2:0] OP_DUMP      = 3'd6;
   localparam logic [2:0] OP_DUMP_REV  = 3'd7;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam int IN_BITS  = 72;
   localparam int OUT_BITS = 40;

endpackage

/* design/cle_ram.sv */
// ----------------------------------------------------------------------------
// Circular list engine RAM
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/circular_list_engine.sv */
// ----------------------------------------------------------------------------
// Circular list engine
// Ordered circular singly linked list of signed values in a node pool.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit first)
//  req     | in        | op[2:0], value[34:3], key[66:35], zero pad to 72
//  rsp     | out       | status[1:0], item_value[33:2], item_count[38:34], pad
//  rsp     | out       | tlast carries last_item
// A request is taken in an idle cycle. A refusal then goes straight to the response state;
// add and delete front pass through the update state first, plus a second link write when
// one is needed. Key searches and delete back pass through a read state, a check of each
// node visited, the update and the response; a missing key skips the update. Dumps walk
// the list the same way, issue the first read, then emit one result per cycle when taken.
// Reset is synchronous and empties the list. The result register holds while rsp_tready
// is low, the sequencer waits on it, and requests wait until the last result is accepted.
module circular_list_engine #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cle_pkg::IN_BITS-1:0]   req_tdata,   // op, value, key
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cle_pkg::OUT_BITS-1:0]  rsp_tdata,   // status, item_value, item_count
   output logic                          rsp_tlast    // last_item
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_RSP  = 3'd4;
   localparam logic [2:0] S_DOUT = 3'd5;
   localparam logic [2:0] S_WR2  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [VALUE_BITS-1:0] val_ff, val_in, key_ff, key_in;
   logic [CAPACITY-1:0]   free_ff, free_in;
   logic [SW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]         cnt_ff, cnt_in, step_ff, step_in;
   logic [SW-1:0]         cur_ff, cur_in, prev_ff, prev_in;
   logic [SW-1:0]         nslot_ff, nslot_in;
   logic [SW-1:0]         order_ff [CAPACITY];
   logic [SW-1:0]         order_in [CAPACITY];
   logic [CW-1:0]         oidx_ff, oidx_in;
   logic                  ovalid_ff, ovalid_in;
   logic [1:0]            ostat_ff, ostat_in;
   logic [31:0]           oval_ff, oval_in;
   logic [CW-1:0]         ocnt_ff, ocnt_in;
   logic                  olast_ff, olast_in;
   logic [SW-1:0]         wlink_ff, wlink_in;
   logic [SW-1:0]         wslot_ff, wslot_in;

   logic                  v_we, l_we;
   logic [SW-1:0]         v_wa, l_wa, rd_a, l_rd;
   logic [VALUE_BITS-1:0] v_wd, v_rd;
   logic [SW-1:0]         l_wd;
   logic [SW-1:0]         lowfree;

   cle_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(rd_a), .rd_data(v_rd));
   cle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_links (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_addr(rd_a), .rd_data(l_rd));

   always_comb begin
      lowfree = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            lowfree = SW'(i);
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {{(cle_pkg::OUT_BITS - 39){1'b0}}, 5'(ocnt_ff), oval_ff, ostat_ff};
   assign rsp_tlast  = olast_ff;

   always_comb begin
      logic full, match, done;
      logic [CW-1:0] ri;
      state_in = state_ff; op_in = op_ff; val_in = val_ff; key_in = key_ff;
      free_in = free_ff; head_in = head_ff; tail_in = tail_ff; cnt_in = cnt_ff;
      step_in = step_ff; cur_in = cur_ff; prev_in = prev_ff; nslot_in = nslot_ff;
      order_in = order_ff; oidx_in = oidx_ff;
      ovalid_in = ovalid_ff; ostat_in = ostat_ff; oval_in = oval_ff;
      ocnt_in = ocnt_ff; olast_in = olast_ff; wlink_in = wlink_ff; wslot_in = wslot_ff;
      v_we = 1'b0; v_wa = nslot_ff; v_wd = val_ff;
      l_we = 1'b0; l_wa = '0; l_wd = '0; rd_a = cur_ff;
      full = (cnt_ff == CW'(CAPACITY));
      match = (v_rd == key_ff);
      ri = '0;
      done = 1'b0;
      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            rd_a = head_ff;
            if (req_tvalid && !ovalid_ff) begin
               op_in  = req_tdata[2:0];
               val_in = VALUE_BITS'(signed'(req_tdata[34:3]));
               key_in = VALUE_BITS'(signed'(req_tdata[66:35]));
               cur_in = head_ff; prev_in = tail_ff; step_in = '0;
               nslot_in = lowfree;
               state_in = S_RD;
               ostat_in = cle_pkg::ST_OK;
               case (req_tdata[2:0])
                  cle_pkg::OP_ADD_FRONT, cle_pkg::OP_ADD_BACK: begin
                     if (full) begin ostat_in = cle_pkg::ST_FULL; state_in = S_RSP; end
                     else state_in = S_UPD;
                  end
                  cle_pkg::OP_INS_KEY: begin
                     if (cnt_ff == '0) begin
                        ostat_in = cle_pkg::ST_EMPTY; state_in = S_RSP;
                     end else if (full) begin
                        ostat_in = cle_pkg::ST_FULL; state_in = S_RSP;
                     end
                  end
                  cle_pkg::OP_DEL_FRONT: begin
                     if (cnt_ff == '0) ostat_in = cle_pkg::ST_EMPTY;
                     else state_in = S_UPD;
                     if (cnt_ff == '0) state_in = S_RSP;
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        ostat_in = cle_pkg::ST_EMPTY; state_in = S_RSP;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            rd_a = cur_ff;
            state_in = S_CHK;
         end
         S_CHK: begin
            // v_rd and l_rd belong to cur_ff.
            case (op_ff)
               cle_pkg::OP_INS_KEY, cle_pkg::OP_DEL_KEY: begin
                  if (match) state_in = S_UPD;
                  else if (step_ff + 1'b1 == cnt_ff) begin
                     ostat_in = cle_pkg::ST_NOT_FOUND; state_in = S_RSP;
                  end else done = 1'b1;
               end
               cle_pkg::OP_DEL_BACK: begin
                  if (cur_ff == tail_ff) begin
                     state_in = S_UPD;
                  end else done = 1'b1;
               end
               default: begin
                  order_in[step_ff[SW-1:0]] = cur_ff;
                  if (step_ff + 1'b1 == cnt_ff) begin
                     state_in = S_DOUT; oidx_in = '0;
                  end else done = 1'b1;
               end
            endcase
            if (done) begin
               step_in = step_ff + 1'b1;
               prev_in = cur_ff;
               cur_in = l_rd;
               rd_a = l_rd;
               state_in = S_CHK;
               // Read issued now; data arrives next cycle for the new cur.
            end
         end
         S_UPD: begin
            state_in = S_RSP;
            case (op_ff)
               cle_pkg::OP_ADD_FRONT, cle_pkg::OP_ADD_BACK: begin
                  v_we = 1'b1; v_wa = nslot_ff;
                  free_in[nslot_ff] = 1'b0;
                  cnt_in = cnt_ff + 1'b1;
                  l_we = 1'b1; l_wa = nslot_ff;
                  if (cnt_ff == '0) begin
                     l_wd = nslot_ff; head_in = nslot_ff; tail_in = nslot_ff;
                  end else begin
                     l_wd = head_ff;
                     wslot_in = tail_ff; wlink_in = nslot_ff; state_in = S_WR2;
                     if (op_ff == cle_pkg::OP_ADD_FRONT) head_in = nslot_ff;
                     else tail_in = nslot_ff;
                  end
               end
               cle_pkg::OP_INS_KEY: begin
                  v_we = 1'b1; v_wa = nslot_ff;
                  free_in[nslot_ff] = 1'b0;
                  cnt_in = cnt_ff + 1'b1;
                  l_we = 1'b1; l_wa = nslot_ff; l_wd = cur_ff;
                  wslot_in = prev_ff; wlink_in = nslot_ff; state_in = S_WR2;
                  if (cur_ff == head_ff) head_in = nslot_ff;
               end
               default: begin
                  // Remove cur_ff with predecessor prev_ff; l_rd is its successor.
                  free_in[cur_ff] = 1'b1;
                  if (cnt_ff <= CW'(1)) begin
                     head_in = '0; tail_in = '0; cnt_in = '0;
                  end else begin
                     cnt_in = cnt_ff - 1'b1;
                     l_we = 1'b1; l_wa = prev_ff; l_wd = l_rd;
                     if (cur_ff == head_ff) head_in = l_rd;
                     if (cur_ff == tail_ff) tail_in = prev_ff;
                  end
               end
            endcase
            if (op_ff == cle_pkg::OP_DEL_FRONT) begin
               // Front removal reaches here without a read; link data comes
               // from the read issued in the request cycle.
               rd_a = cur_ff;
            end
         end
         S_WR2: begin
            l_we = 1'b1; l_wa = wslot_ff; l_wd = wlink_ff;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1; oval_in = '0; ocnt_in = cnt_ff; olast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DOUT: begin
            if (op_ff == cle_pkg::OP_DUMP) ri = oidx_ff - 1'b1;
            else ri = cnt_ff - oidx_ff;
            rd_a = order_ff[ri[SW-1:0]];
            if (!ovalid_ff || rsp_tready) begin
               if (oidx_ff != '0) begin
                  ovalid_in = 1'b1; ostat_in = cle_pkg::ST_OK;
                  oval_in = 32'(signed'(v_rd)); ocnt_in = cnt_ff;
                  olast_in = (oidx_ff == cnt_ff);
                  if (oidx_ff == cnt_ff) state_in = S_IDLE;
               end
               if (oidx_ff != cnt_ff) oidx_in = oidx_ff + 1'b1;
               if (op_ff == cle_pkg::OP_DUMP) ri = oidx_ff;
               else ri = cnt_ff - 1'b1 - oidx_ff;
               rd_a = order_ff[ri[SW-1:0]];
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; free_ff <= '1; head_ff <= '0; tail_ff <= '0;
         cnt_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; free_ff <= free_in; head_ff <= head_in;
         tail_ff <= tail_in; cnt_ff <= cnt_in; ovalid_ff <= ovalid_in;
      end
      op_ff <= op_in; val_ff <= val_in; key_ff <= key_in; step_ff <= step_in;
      cur_ff <= cur_in; prev_ff <= prev_in; nslot_ff <= nslot_in;
      order_ff <= order_in; oidx_ff <= oidx_in; ostat_ff <= ostat_in;
      oval_ff <= oval_in; ocnt_ff <= ocnt_in; olast_ff <= olast_in;
      wlink_ff <= wlink_in; wslot_ff <= wslot_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");
   assert property (@(posedge clock) disable iff (reset)
      $countones(~free_ff) == int'(cnt_ff))
      else $error("free map disagrees with entry count");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while busy");

endmodule

/* bench/circular_list_engine_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular list engine checker
// Watches the request and response channels, keeps its own copy of the list
// and compares every response, all fields at once, with the oldest prediction.
// ----------------------------------------------------------------------------
module circular_list_engine_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [cle_pkg::IN_BITS-1:0]   req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [cle_pkg::OUT_BITS-1:0]  rsp_tdata,
   input  logic                          rsp_tlast,
   output int                            fail_count,
   output int                            pending_count
);

   localparam int SLOTS = 16;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] item_value;
      logic [4:0]  item_count;
      logic        last_item;
   } response_type;

   response_type   pending_q[$];
   logic [31:0]    list_q[$];

   function automatic int find_first(input logic [31:0] key);
      for (int i = 0; i < list_q.size(); i++)
         if (list_q[i] == key) return i;
      return -1;
   endfunction

   task automatic predict(input logic [2:0] op, input logic [31:0] value,
                          input logic [31:0] key);
      response_type r;
      int        pos;
      logic [1:0] st;
      st = cle_pkg::ST_OK;
      if (op == cle_pkg::OP_DUMP || op == cle_pkg::OP_DUMP_REV) begin
         if (list_q.size() == 0) begin
            r = '{cle_pkg::ST_EMPTY, 32'd0, 5'd0, 1'b1};
            pending_q.push_back(r);
         end else begin
            for (int k = 0; k < list_q.size(); k++) begin
               r.status = cle_pkg::ST_OK;
               r.item_value = (op == cle_pkg::OP_DUMP) ? list_q[k] :
                              list_q[list_q.size() - 1 - k];
               r.item_count = 5'(list_q.size());
               r.last_item = (k == list_q.size() - 1);
               pending_q.push_back(r);
            end
         end
         return;
      end
      case (op)
         cle_pkg::OP_ADD_FRONT, cle_pkg::OP_ADD_BACK: begin
            if (list_q.size() >= SLOTS) st = cle_pkg::ST_FULL;
            else if (op == cle_pkg::OP_ADD_FRONT) list_q.push_front(value);
            else list_q.push_back(value);
         end
         cle_pkg::OP_INS_KEY: begin
            if (list_q.size() == 0) st = cle_pkg::ST_EMPTY;
            else if (list_q.size() >= SLOTS) st = cle_pkg::ST_FULL;
            else begin
               pos = find_first(key);
               if (pos < 0) st = cle_pkg::ST_NOT_FOUND;
               else list_q.insert(pos, value);
            end
         end
         cle_pkg::OP_DEL_FRONT: begin
            if (list_q.size() == 0) st = cle_pkg::ST_EMPTY;
            else void'(list_q.pop_front());
         end
         cle_pkg::OP_DEL_BACK: begin
            if (list_q.size() == 0) st = cle_pkg::ST_EMPTY;
            else void'(list_q.pop_back());
         end
         default: begin
            if (list_q.size() == 0) st = cle_pkg::ST_EMPTY;
            else begin
               pos = find_first(key);
               if (pos < 0) st = cle_pkg::ST_NOT_FOUND;
               else list_q.delete(pos);
            end
         end
      endcase
      r = '{st, 32'd0, 5'(list_q.size()), 1'b1};
      pending_q.push_back(r);
   endtask

   always @(posedge clock) begin
      response_type got, want;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
         pending_q.delete();
         list_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[38:34], rsp_tlast};
            if (pending_q.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected response %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"Mismatch: expected st=%0d val=%h cnt=%0d last=%b, ",
                               "got st=%0d val=%h cnt=%0d last=%b"},
                              want.status, want.item_value, want.item_count,
                              want.last_item, got.status, got.item_value,
                              got.item_count, got.last_item);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict(req_tdata[2:0], req_tdata[34:3], req_tdata[66:35]);
         pending_count <= pending_q.size();
      end
   end
endmodule

/* bench/circular_list_engine_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular list engine test
// Directed and random requests with random idle bursts on both channels;
// the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module circular_list_engine_test;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [cle_pkg::IN_BITS-1:0]  req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [cle_pkg::OUT_BITS-1:0] rsp_tdata;
   logic                         rsp_tlast;
   int                           fail_count;
   int                           pending_count;
   int                           idle_cycles = 0;
   bit                           calm = 1'b0;
   logic [31:0]                  recent[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   circular_list_engine uut (.*);

   circular_list_engine_check checker_i (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 4);
            rsp_tready <= 1'b0;
            repeat (burst) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return recent.size() ? recent[$urandom_range(0, recent.size() - 1)] : 32'd0;
         3: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input logic [2:0] op, input logic [31:0] value, input logic [31:0] key);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, key, value, op};
      if (op <= cle_pkg::OP_INS_KEY) begin
         recent.push_back(value);
         if (recent.size() > 24) void'(recent.pop_front());
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [2:0] op;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(cle_pkg::OP_DUMP, 0, 0);
      send(cle_pkg::OP_DEL_FRONT, 0, 0);
      send(cle_pkg::OP_DEL_BACK, 0, 0);
      send(cle_pkg::OP_DEL_KEY, 0, 5);
      send(cle_pkg::OP_INS_KEY, 1, 0);
      send(cle_pkg::OP_ADD_BACK, 32'h8000_0000, 0);
      send(cle_pkg::OP_DEL_BACK, 0, 0);
      send(cle_pkg::OP_ADD_FRONT, 32'h7FFF_FFFF, 0);
      send(cle_pkg::OP_DEL_FRONT, 0, 0);
      for (int i = 0; i < 16; i++)
         send(i[0] ? cle_pkg::OP_ADD_FRONT : cle_pkg::OP_ADD_BACK, i * 3 - 20, 0);
      send(cle_pkg::OP_ADD_BACK, 99, 0);
      send(cle_pkg::OP_INS_KEY, 99, 10);
      send(cle_pkg::OP_DUMP, 0, 0);
      send(cle_pkg::OP_DUMP_REV, 0, 0);
      send(cle_pkg::OP_DEL_KEY, 0, 32'hFFFF_FFEC);
      send(cle_pkg::OP_INS_KEY, 32'hFFFF_FFFF, 32'h1234);
      send(cle_pkg::OP_INS_KEY, 32'hFFFF_FFFF, 32'hFFFF_FFEF);
      send(cle_pkg::OP_DEL_KEY, 0, 32'h5555);
      for (int i = 0; i < 386; i++) begin
         if (i == 330) calm = 1'b1;
         op = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 9) < 3) op = 3'($urandom_range(0, 1));
         send(op, pick_value(), pick_value());
      end
      send(cle_pkg::OP_DUMP_REV, 0, 0);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

/* filelist.f */
design/cle_pkg.sv
design/cle_ram.sv
design/circular_list_engine.sv
bench/circular_list_engine_check.sv
bench/circular_list_engine_test.sv
